[hdl/rgb_to_hsv_pixel_converter_macros.svh]
// ----------------------------------------------------------------------------
// rgb to hsv pixel converter assertion macros
// clocked assertion helpers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_PIXEL_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define R2H_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// antecedent on one edge implies consequent on the next
`define R2H_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define R2H_ASSERT(label, prop, msg)
`define R2H_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[hdl/rgb2hsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgb2hsv package
// default widths and the hue sector code of the rgb to hsv converter
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

  // default channel width and hue / saturation fraction width
  localparam int unsigned ChannelBitsDef  = 8;
  localparam int unsigned FractionBitsDef = 16;

  // which channel holds the maximum, in tie order
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

endpackage

[hdl/rgb_to_hsv_pixel_converter.sv]
// ----------------------------------------------------------------------------
// rgb to hsv pixel converter
// streaming hexcone rgb to hsv conversion with two pipelined dividers
// ----------------------------------------------------------------------------
// one pixel word in, one hsv word out, with a new pixel taken on every clock
// unless stalled. the pipeline has three front stages (max / min and sector
// select, chroma, hue numerator and divisor set-up), one stage per quotient
// bit in which the hue and saturation restoring dividers each settle one bit,
// and an output register. each stage has its own valid bit and takes a new
// word whenever it is empty or its successor moves on, so a stall at the
// output fills bubbles before it holds back the input.
module rgb_to_hsv_pixel_converter #(
  parameter int unsigned CHANNEL_BITS  = rgb2hsv_pkg::ChannelBitsDef,
  parameter int unsigned FRACTION_BITS = rgb2hsv_pkg::FractionBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  // slave side: red, green, blue from bit 0 up, zero padded to bytes
  input  logic                                              s_axis_tvalid,
  output logic                                              s_axis_tready,
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]               s_axis_tdata,
  // master side: hue, saturation, brightness from bit 0 up, zero padded
  output logic                                              m_axis_tvalid,
  input  logic                                              m_axis_tready,
  output logic [((2*FRACTION_BITS+CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata
);

  import rgb2hsv_pkg::*;

  `include "rgb_to_hsv_pixel_converter_macros.svh"

  localparam int unsigned CB     = CHANNEL_BITS;
  localparam int unsigned FB     = FRACTION_BITS;
  // hue remainder and six times chroma fit in cb + 3 bits
  localparam int unsigned HW     = CB + 3;
  localparam int unsigned NSTG   = FB + 4;
  localparam int unsigned OUT_W  = ((2*FB+CB+7)/8)*8;
  localparam int unsigned PAD_W  = OUT_W - 2*FB - CB;

  // per stage valid bits and the ready chain running back from the output
  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   rdy;

  assign rdy[NSTG] = m_axis_tready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: maximum, minimum, sector and the signed channel difference
  // --------------------------------------------------------------------------
  logic [CB-1:0]        red, green, blue;
  logic [CB-1:0]        max_d, min_d;
  sector_e              sec_d;
  logic signed [CB:0]   diff_d;

  assign red   = s_axis_tdata[CB-1:0];
  assign green = s_axis_tdata[2*CB-1:CB];
  assign blue  = s_axis_tdata[3*CB-1:2*CB];

  always_comb begin
    // red wins ties, then green
    if (red >= green && red >= blue) begin
      sec_d  = SEC_RED;
      max_d  = red;
      diff_d = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      sec_d  = SEC_GREEN;
      max_d  = green;
      diff_d = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sec_d  = SEC_BLUE;
      max_d  = blue;
      diff_d = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    if (red <= green && red <= blue) begin
      min_d = red;
    end else if (green <= blue) begin
      min_d = green;
    end else begin
      min_d = blue;
    end
  end

  logic [CB-1:0]      s0_max_q, s0_min_q;
  sector_e            s0_sec_q;
  logic signed [CB:0] s0_diff_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_max_q  <= max_d;
      s0_min_q  <= min_d;
      s0_sec_q  <= sec_d;
      s0_diff_q <= diff_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: chroma
  // --------------------------------------------------------------------------
  logic [CB-1:0]      s1_val_q, s1_chroma_q;
  sector_e            s1_sec_q;
  logic signed [CB:0] s1_diff_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_val_q    <= s0_max_q;
      s1_chroma_q <= s0_max_q - s0_min_q;
      s1_sec_q    <= s0_sec_q;
      s1_diff_q   <= s0_diff_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: hue numerator in [0, 6c), divisor 6c and saturation dividend
  // --------------------------------------------------------------------------
  logic [HW-1:0]        c2, c4, d6_d;
  logic signed [HW:0]   off, num_s;
  logic [CB+FB-1:0]     sat_num;

  assign c2   = HW'({s1_chroma_q, 1'b0});
  assign c4   = HW'({s1_chroma_q, 2'b00});
  assign d6_d = c2 + c4;

  always_comb begin
    unique case (s1_sec_q)
      // a negative red sector hue wraps by one full turn
      SEC_RED:   off = (s1_diff_q < 0) ? $signed({1'b0, d6_d}) : '0;
      SEC_GREEN: off = $signed({1'b0, c2});
      default:   off = $signed({1'b0, c4});
    endcase
    num_s = (HW+1)'(s1_diff_q) + off;
  end

  // chroma * (2^fb - 1)
  assign sat_num = {s1_chroma_q, {FB{1'b0}}} - (CB+FB)'(s1_chroma_q);

  // division pipeline arrays: entry 0 is filled by stage 2, entry j+1 by
  // quotient stage j
  logic [HW-1:0] rh_q   [FB+1];
  logic [HW-1:0] dh_q   [FB+1];
  logic [CB-1:0] rs_q   [FB+1];
  logic [FB-1:0] xb_q   [FB+1];
  logic [FB-1:0] qh_q   [FB+1];
  logic [FB-1:0] qs_q   [FB+1];
  logic [CB-1:0] val_q  [FB+1];
  logic          grey_q [FB+1];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      rh_q[0]   <= num_s[HW-1:0];
      dh_q[0]   <= d6_d;
      rs_q[0]   <= sat_num[CB+FB-1:FB];
      xb_q[0]   <= sat_num[FB-1:0];
      qh_q[0]   <= '0;
      qs_q[0]   <= '0;
      val_q[0]  <= s1_val_q;
      grey_q[0] <= (s1_chroma_q == '0);
    end
  end

  // --------------------------------------------------------------------------
  // quotient stages: one restoring step of each divider per stage
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < FB; j++) begin : g_div
    logic [HW:0]   th;
    logic [CB:0]   ts;
    logic          hbit, sbit;
    logic [HW-1:0] rh_d;
    logic [CB-1:0] rs_d;

    always_comb begin
      th   = {rh_q[j], 1'b0};
      hbit = (th >= {1'b0, dh_q[j]});
      rh_d = hbit ? HW'(th - {1'b0, dh_q[j]}) : th[HW-1:0];
      ts   = {rs_q[j], xb_q[j][FB-1]};
      sbit = (ts >= {1'b0, val_q[j]});
      rs_d = sbit ? CB'(ts - {1'b0, val_q[j]}) : ts[CB-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (rdy[3+j]) begin
        rh_q[j+1]   <= rh_d;
        dh_q[j+1]   <= dh_q[j];
        rs_q[j+1]   <= rs_d;
        xb_q[j+1]   <= {xb_q[j][FB-2:0], 1'b0};
        qh_q[j+1]   <= {qh_q[j][FB-2:0], hbit};
        qs_q[j+1]   <= {qs_q[j][FB-2:0], sbit};
        val_q[j+1]  <= val_q[j];
        grey_q[j+1] <= grey_q[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register: grey pixels carry zero hue and saturation
  // --------------------------------------------------------------------------
  logic [FB-1:0] hue_q, sat_q;
  logic [CB-1:0] bright_q;

  always_ff @(posedge clk_i) begin
    if (rdy[NSTG-1]) begin
      hue_q    <= grey_q[FB] ? '0 : qh_q[FB];
      sat_q    <= grey_q[FB] ? '0 : qs_q[FB];
      bright_q <= val_q[FB];
    end
  end

  if (PAD_W > 0) begin : g_pad
    assign m_axis_tdata = {{PAD_W{1'b0}}, bright_q, sat_q, hue_q};
  end else begin : g_nopad
    assign m_axis_tdata = {bright_q, sat_q, hue_q};
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `R2H_ASSERT_NEXT(a_in_lands, s_axis_tvalid && s_axis_tready, vld_q[0],
    "accepted pixel did not enter the first stage")
  `R2H_ASSERT(a_black_out, !(m_axis_tvalid && bright_q == '0) || (hue_q == '0 && sat_q == '0),
    "black pixel with non-zero hue or saturation")
  `R2H_ASSERT(a_sat_bright, !(m_axis_tvalid && sat_q != '0) || bright_q != '0,
    "saturation set with zero brightness")
  `R2H_ASSERT(a_hue_rem, !(vld_q[FB+2] && !grey_q[FB]) || rh_q[FB] < dh_q[FB],
    "hue remainder not below divisor after last quotient step")

endmodule
